[rtl/core/bhsf_pkg.sv]
// Shared types, constants and mask helpers for the span fill core.
`default_nettype none

package bhsf_pkg;

  // Default framebuffer geometry
  localparam int DEF_MAX_WIDTH_PIXELS = 256;
  localparam int DEF_MAX_HEIGHT_ROWS  = 256;

  // Field and register widths
  localparam int COL_W       = 8;
  localparam int ROW_W       = 8;
  localparam int RADDR_W     = 13;
  localparam int DATA_W      = 8;
  localparam int RB_W        = 6;
  localparam int ROWS_W      = 9;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int BYTE_IDX_W  = COL_W - 3;
  localparam int DRAW_ADDR_W = ROW_W + RB_W;

  localparam logic [RB_W-1:0]   RB_RESET   = RB_W'(4);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(32);
  localparam int RB_LIMIT   = (1 << RB_W) - 1;
  localparam int ROWS_LIMIT = (1 << ROWS_W) - 1;

  localparam logic [DATA_W-1:0] FULL_BYTE = 8'hff;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

  // Item kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FILL,
    ST_DRAIN,
    ST_DONE
  } bhsf_state_e;

  typedef struct packed {
    logic clear;
    logic load_item;
    logic check;
    logic fill;
    logic load_out;
  } bhsf_cmd_t;

  typedef struct packed {
    logic kind_read;
    logic err;
    logic fill_last;
    logic clr_last;
  } bhsf_sts_t;

  // Pixels from column bit upward within the first byte
  function automatic logic [DATA_W-1:0] start_mask(input logic [2:0] bit_i);
    start_mask = FULL_BYTE << bit_i;
  endfunction

  // Pixels up to and including column bit within the last byte
  function automatic logic [DATA_W-1:0] end_mask(input logic [2:0] bit_i);
    end_mask = FULL_BYTE >> (~bit_i);
  endfunction

endpackage

`default_nettype wire

[rtl/core/bhsf_ctrl.sv]
// Sequencer for clear, range check, byte fill and result hand-off.
`default_nettype none

module bhsf_ctrl import bhsf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire bhsf_sts_t sts_i,
  output bhsf_cmd_t      cmd_o
);

  bhsf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!sts_i.kind_read && !sts_i.err) state_d = ST_FILL;
        else state_d = ST_DONE;
      end
      ST_FILL:  if (sts_i.fill_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.clear     = (state_q == ST_CLEAR);
    cmd_o.load_item = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.check     = (state_q == ST_CHECK);
    cmd_o.fill      = (state_q == ST_FILL);
    cmd_o.load_out  = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CHECK))
    else $error("accepted item did not move to range check");

  a_drain_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_DONE))
    else $error("drain did not finish in one cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside of done state");

endmodule

`default_nettype wire

[rtl/core/bhsf_dp.sv]
// Datapath: config registers, item registers, framebuffer memory and result register.
`default_nettype none

module bhsf_dp import bhsf_pkg::*; #(
  parameter int MAX_WIDTH_PIXELS = DEF_MAX_WIDTH_PIXELS,
  parameter int MAX_HEIGHT_ROWS  = DEF_MAX_HEIGHT_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 kind_i,
  input  wire logic [COL_W-1:0]     x_start_i,
  input  wire logic [COL_W-1:0]     x_end_i,
  input  wire logic [ROW_W-1:0]     row_i,
  input  wire logic [RADDR_W-1:0]   read_address_i,
  input  wire bhsf_cmd_t            cmd_i,
  output bhsf_sts_t                 sts_o,
  output logic [DATA_W-1:0]         read_data_o,
  output logic                      status_o
);

  localparam int MAX_ROW_BYTES = MAX_WIDTH_PIXELS / 8;
  localparam int STORE_BYTES   = MAX_ROW_BYTES * MAX_HEIGHT_ROWS;
  localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int AX_W          = (ADDR_W > DRAW_ADDR_W) ? ADDR_W : DRAW_ADDR_W;
  localparam int WIDE_W        = AX_W + 1;
  localparam int RB_MAX        = (MAX_ROW_BYTES > RB_LIMIT) ? RB_LIMIT : MAX_ROW_BYTES;
  localparam int ROWS_MAX      = (MAX_HEIGHT_ROWS > ROWS_LIMIT) ? ROWS_LIMIT : MAX_HEIGHT_ROWS;

  // Configuration
  logic [RB_W-1:0]   row_bytes_q;
  logic [ROWS_W-1:0] rows_in_use_q;
  logic [RB_W-1:0]   eff_rb;
  logic [ROWS_W-1:0] eff_rows;

  // Item
  logic               kind_q;
  logic [COL_W-1:0]   xs_q, xe_q;
  logic [ROW_W-1:0]   row_q;
  logic [RADDR_W-1:0] raddr_q;

  // Draw walk
  logic                   err_q;
  logic [DRAW_ADDR_W-1:0] base_q;
  logic [BYTE_IDX_W-1:0]  b_q;
  logic                   wr_pend_q;
  logic [ADDR_W-1:0]      wr_addr_q;
  logic [DATA_W-1:0]      wr_mask_q;
  logic [ADDR_W-1:0]      clr_q;

  // Memory
  logic [DATA_W-1:0] mem_q [STORE_BYTES];
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_en, mem_we;
  logic [ADDR_W-1:0] rd_addr, mem_wa;
  logic [DATA_W-1:0] mem_wd;

  logic [DATA_W-1:0] read_data_q;
  logic              status_q;

  logic                   err_c, rd_ok;
  logic [WIDE_W-1:0]      raddr_ext;
  logic [DRAW_ADDR_W-1:0] base_c, draw_addr_c;
  logic [DATA_W-1:0]      mask_c;
  logic [BYTE_IDX_W-1:0]  first_b, last_b;
  logic [AX_W-1:0]        draw_addr_ax;

  // Clamp registers to the legal geometry
  always_comb begin
    if (row_bytes_q == '0) eff_rb = RB_W'(1);
    else if (row_bytes_q > RB_W'(RB_MAX)) eff_rb = RB_W'(RB_MAX);
    else eff_rb = row_bytes_q;
    if (rows_in_use_q == '0) eff_rows = ROWS_W'(1);
    else if (rows_in_use_q > ROWS_W'(ROWS_MAX)) eff_rows = ROWS_W'(ROWS_MAX);
    else eff_rows = rows_in_use_q;
  end

  assign first_b   = xs_q[COL_W-1:3];
  assign last_b    = xe_q[COL_W-1:3];
  assign raddr_ext = WIDE_W'(raddr_q);
  assign rd_ok     = raddr_ext < WIDE_W'(STORE_BYTES);
  assign base_c    = DRAW_ADDR_W'(row_q) * DRAW_ADDR_W'(eff_rb);

  always_comb begin
    if (kind_q == KIND_READ) begin
      err_c = !rd_ok;
    end else begin
      err_c = (xs_q > xe_q) || ({1'b0, last_b} >= eff_rb) || ({1'b0, row_q} >= eff_rows);
    end
  end

  assign draw_addr_c = base_q + DRAW_ADDR_W'(b_q);

  always_comb begin
    mask_c = FULL_BYTE;
    if (b_q == first_b) mask_c = mask_c & start_mask(xs_q[2:0]);
    if (b_q == last_b) mask_c = mask_c & end_mask(xe_q[2:0]);
  end

  assign draw_addr_ax = AX_W'(draw_addr_c);

  assign rd_en   = cmd_i.fill || (cmd_i.check && (kind_q == KIND_READ) && rd_ok);
  assign rd_addr = cmd_i.fill ? draw_addr_ax[ADDR_W-1:0] : raddr_ext[ADDR_W-1:0];
  assign mem_we  = cmd_i.clear || wr_pend_q;
  assign mem_wa  = cmd_i.clear ? clr_q : wr_addr_q;
  assign mem_wd  = cmd_i.clear ? '0 : (rd_data_q | wr_mask_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= RB_RESET;
      rows_in_use_q <= ROWS_RESET;
      wr_pend_q     <= 1'b0;
      clr_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROW_BYTES:   row_bytes_q   <= cfg_data_i[RB_W-1:0];
          CFG_ROWS_IN_USE: rows_in_use_q <= cfg_data_i[ROWS_W-1:0];
          default: ;
        endcase
      end
      wr_pend_q <= cmd_i.fill;
      if (cmd_i.clear) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      xs_q    <= x_start_i;
      xe_q    <= x_end_i;
      row_q   <= row_i;
      raddr_q <= read_address_i;
    end
    if (cmd_i.check) begin
      err_q  <= err_c;
      base_q <= base_c;
      b_q    <= first_b;
    end
    if (cmd_i.fill) begin
      b_q       <= b_q + BYTE_IDX_W'(1);
      wr_addr_q <= draw_addr_ax[ADDR_W-1:0];
      wr_mask_q <= mask_c;
    end
    if (cmd_i.load_out) begin
      read_data_q <= ((kind_q == KIND_READ) && !err_q) ? rd_data_q : '0;
      status_q    <= err_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.kind_read = (kind_q == KIND_READ);
    sts_o.err       = err_c;
    sts_o.fill_last = (b_q == last_b);
    sts_o.clr_last  = (clr_q == ADDR_W'(STORE_BYTES - 1));
  end

  assign read_data_o = read_data_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

[rtl/core/bitmap_horizontal_span_fill_core.sv]
// Top level: 1-bpp framebuffer with horizontal span fill and byte read.
// Draw item: accepted, range checked, then filled byte by byte from the first to the last
//   byte, one framebuffer byte read-modify-written per cycle, then drained before the result.
// Read item or rejected draw: goes from range check straight to the result, with no fill.
// After reset the memory is swept to zero, one byte per cycle, over all
//   (MAX_WIDTH_PIXELS/8)*MAX_HEIGHT_ROWS bytes (8192 by default); no item is taken meanwhile.
`default_nettype none

module bitmap_horizontal_span_fill_core import bhsf_pkg::*; #(
  parameter int MAX_WIDTH_PIXELS = DEF_MAX_WIDTH_PIXELS,
  parameter int MAX_HEIGHT_ROWS  = DEF_MAX_HEIGHT_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [COL_W-1:0]     x_start_i,
  input  wire logic [COL_W-1:0]     x_end_i,
  input  wire logic [ROW_W-1:0]     row_i,
  input  wire logic [RADDR_W-1:0]   read_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DATA_W-1:0]         read_data_o,
  output logic                      status_o
);

  bhsf_cmd_t cmd;
  bhsf_sts_t sts;

  bhsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bhsf_dp #(
    .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
    .MAX_HEIGHT_ROWS  (MAX_HEIGHT_ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .x_start_i      (x_start_i),
    .x_end_i        (x_end_i),
    .row_i          (row_i),
    .read_address_i (read_address_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .read_data_o    (read_data_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
